// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers shared by the rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every rising clock edge outside reset
`define ASSERT_PROP(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");

// condition must never be true outside reset
`define ASSERT_NEVER(label, clk, rst, cond) \
   `ASSERT_PROP(label, clk, rst, !(cond))

`endif

// ===== design/nthss_pkg.sv =====
// ----------------------------------------------------------------------------
// nthss_pkg
// shared types, constants and helpers of the n-th occurrence search
// ----------------------------------------------------------------------------
package nthss_pkg;

   localparam int WIN_DEPTH    = 16;
   localparam int WIN_IDX_W    = 4;
   localparam int LEN_W        = 5;
   localparam int CSR_ADDR_W   = 2;
   localparam int CSR_DATA_W   = 64;
   localparam int OCC_W        = 16;
   localparam int COUNT_W      = 13;
   localparam int START_W      = 12;

   localparam logic [CSR_ADDR_W-1:0] CSR_PATTERN_LENGTH    = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_PATTERN_LOW       = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_PATTERN_HIGH      = 2'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_OCCURRENCE_NUMBER = 2'd3;

   typedef logic [7:0] byte_type;

   typedef struct packed {
      logic [LEN_W-1:0]      pattern_length;
      logic [CSR_DATA_W-1:0] pattern_high;
      logic [CSR_DATA_W-1:0] pattern_low;
      logic [OCC_W-1:0]      occurrence_number;
   } cfg_type;

   typedef struct packed {
      logic shift;
      logic clear;
   } win_ctl_type;

   // zero reads as one, anything above the window depth saturates
   function automatic logic [LEN_W-1:0] active_len(input logic [LEN_W-1:0] len);
      logic [LEN_W-1:0] res;
      res = len;
      if (len == '0) begin
         res = LEN_W'(1);
      end else if (len > LEN_W'(WIN_DEPTH)) begin
         res = LEN_W'(WIN_DEPTH);
      end
      return res;
   endfunction

endpackage

// ===== design/nthss_csr.sv =====
// ----------------------------------------------------------------------------
// nthss_csr
// configuration registers written through the csr port
// ----------------------------------------------------------------------------
module nthss_csr import nthss_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output cfg_type               cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_addr)
            CSR_PATTERN_LENGTH:    cfg_in.pattern_length    = csr_wdata[LEN_W-1:0];
            CSR_PATTERN_LOW:       cfg_in.pattern_low       = csr_wdata;
            CSR_PATTERN_HIGH:      cfg_in.pattern_high      = csr_wdata;
            CSR_OCCURRENCE_NUMBER: cfg_in.occurrence_number = csr_wdata[OCC_W-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pattern_length    <= LEN_W'(1);
         cfg_ff.pattern_low       <= '0;
         cfg_ff.pattern_high      <= '0;
         cfg_ff.occurrence_number <= OCC_W'(1);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== design/nthss_window.sv =====
// ----------------------------------------------------------------------------
// nthss_window
// window of recent text bytes and parallel compare with the pattern
// ----------------------------------------------------------------------------
module nthss_window import nthss_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  win_ctl_type ctl,
   input  byte_type    text_byte,
   input  cfg_type     cfg,
   output logic        match
);

   byte_type                  recent_ff [WIN_DEPTH];
   byte_type                  recent_in [WIN_DEPTH];
   byte_type                  shifted   [WIN_DEPTH];
   logic [2*CSR_DATA_W-1:0]   pattern;
   logic [LEN_W-1:0]          len;
   logic [WIN_IDX_W-1:0]      len_m1;
   logic [WIN_IDX_W-1:0]      idx;

   assign pattern = {cfg.pattern_high, cfg.pattern_low};
   assign len     = active_len(cfg.pattern_length);
   assign len_m1  = WIN_IDX_W'(len - LEN_W'(1));

   // newest byte at index zero
   always_comb begin
      shifted[0] = text_byte;
      for (int i = 1; i < WIN_DEPTH; i++) begin
         shifted[i] = recent_ff[i-1];
      end
   end

   always_comb begin
      match = 1'b1;
      idx   = '0;
      for (int j = 0; j < WIN_DEPTH; j++) begin
         idx = len_m1 - WIN_IDX_W'(j);
         if ((WIN_IDX_W'(j) <= len_m1) && (shifted[idx] != pattern[8*j +: 8])) begin
            match = 1'b0;
         end
      end
   end

   always_comb begin
      for (int i = 0; i < WIN_DEPTH; i++) begin
         if (ctl.clear) begin
            recent_in[i] = '0;
         end else if (ctl.shift) begin
            recent_in[i] = shifted[i];
         end else begin
            recent_in[i] = recent_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < WIN_DEPTH; i++) begin
            recent_ff[i] <= '0;
         end
      end else begin
         recent_ff <= recent_in;
      end
   end

endmodule

// ===== design/nth_occurrence_substring_search.sv =====
// ----------------------------------------------------------------------------
// nth_occurrence_substring_search
// streams text bytes and reports where the n-th pattern occurrence begins
//
//   channel  direction  payload
//   req      in         tdata[7:0] text_byte, tlast last
//   rsp      out        tdata[11:0] match_start, tuser found
//   csr      in         addr register index, wdata register value
//
// one byte accepted per cycle unless rsp stalls; the input register feeds the rsp register
// throughput is set by the combinational window compare after the input register
// synchronous active-high reset clears search state and loads register defaults
// a stalled rsp holds both stages and drops req_tready once the input stage is full
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module nth_occurrence_substring_search import nthss_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [7:0]            req_tdata,   // text_byte
   input  logic                  req_tlast,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [15:0]           rsp_tdata,   // match_start, zero fill
   output logic                  rsp_tuser,   // found
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cfg_type              cfg;
   win_ctl_type          win_ctl;
   logic                 match;

   logic                 in_valid_ff;
   byte_type             in_byte_ff;
   logic                 in_last_ff;

   logic [COUNT_W-1:0]   count_ff;
   logic [COUNT_W-1:0]   count_in;
   logic [OCC_W-1:0]     seen_ff;
   logic [OCC_W-1:0]     seen_in;
   logic                 reported_ff;
   logic                 reported_in;

   logic                 rsp_valid_ff;
   logic                 rsp_valid_in;
   logic                 rsp_found_ff;
   logic [START_W-1:0]   rsp_start_ff;

   logic                 advance;
   logic                 proc;
   logic                 active;
   logic [COUNT_W-1:0]   count_next;
   logic [LEN_W-1:0]     len;
   logic                 hit;
   logic [OCC_W-1:0]     seen_next;
   logic                 fire;

   nthss_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   nthss_window u_window (
      .clock     (clock),
      .reset     (reset),
      .ctl       (win_ctl),
      .text_byte (in_byte_ff),
      .cfg       (cfg),
      .match     (match)
   );

   assign advance    = !rsp_valid_ff || rsp_tready;
   assign req_tready = !in_valid_ff || advance;
   assign proc       = in_valid_ff && advance;

   assign len        = active_len(cfg.pattern_length);
   assign active     = !count_ff[COUNT_W-1];
   assign count_next = count_ff + COUNT_W'(1);
   assign hit        = active && !reported_ff && (count_next >= COUNT_W'(len)) && match;
   assign seen_next  = (hit && (seen_ff != '1)) ? seen_ff + OCC_W'(1) : seen_ff;
   assign fire       = hit && (seen_next == cfg.occurrence_number);

   assign win_ctl.shift = proc && active;
   assign win_ctl.clear = proc && in_last_ff;

   always_comb begin
      count_in     = count_ff;
      seen_in      = seen_ff;
      reported_in  = reported_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      if (proc) begin
         rsp_valid_in = fire || (in_last_ff && !reported_ff);
         if (in_last_ff) begin
            count_in    = '0;
            seen_in     = '0;
            reported_in = 1'b0;
         end else begin
            if (active) begin
               count_in = count_next;
            end
            seen_in     = seen_next;
            reported_in = reported_ff || fire;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         count_ff     <= '0;
         seen_ff      <= '0;
         reported_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            in_valid_ff <= 1'b1;
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end
         count_ff     <= count_in;
         seen_ff      <= seen_in;
         reported_ff  <= reported_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_byte_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
      if (proc) begin
         rsp_found_ff <= fire;
         rsp_start_ff <= fire ? START_W'(count_next - COUNT_W'(len)) : '0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_found_ff;
   assign rsp_tdata  = {{(16-START_W){1'b0}}, rsp_start_ff};

   `ASSERT_PROP(fire_sets_reported, clock, reset, (proc && fire && !in_last_ff) |=> reported_ff)
   `ASSERT_PROP(last_clears_search, clock, reset,
      (proc && in_last_ff) |=> (count_ff == '0 && seen_ff == '0 && !reported_ff))
   `ASSERT_NEVER(count_overflow, clock, reset, count_ff > COUNT_W'(4096))
   `ASSERT_NEVER(miss_has_start, clock, reset, rsp_valid_ff && !rsp_found_ff && rsp_start_ff != '0)

endmodule
